// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pas_pkg.sv
// shared types, codes and command/status structs of the positional array store
// used by the controller, the datapath and the top level
package pas_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int MAX_RUN        = 32;

    localparam int OP_W       = 4;
    localparam int POS_W      = 6;
    localparam int POS2_W     = 5;
    localparam int RUN_W      = 6;
    localparam int ELEM_IN_W  = 32;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 6;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 4'd0,
        OP_INSERT = 4'd1,
        OP_POP    = 4'd2,
        OP_REMOVE = 4'd3,
        OP_RUN    = 4'd4,
        OP_GET    = 4'd5,
        OP_SET    = 4'd6,
        OP_SWAP   = 4'd7,
        OP_SORT   = 4'd8,
        OP_CLEAR  = 4'd9
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RA_POS, RA_POS2, RA_LENM1, RA_IDXM1, RA_IDXK, RA_POSJDX, RA_IDX, RA_JDX
    } rd_sel_t;

    typedef enum logic [2:0] {
        WA_LEN, WA_POS, WA_POS2, WA_IDX, WA_JDX
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_ELEM, WD_RDATA, WD_HOLD
    } wd_sel_t;

    typedef enum logic [2:0] {
        IDX_KEEP, IDX_LEN, IDX_POS, IDX_ZERO, IDX_INC, IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        JDX_KEEP, JDX_ZERO, JDX_IDXP1, JDX_INC
    } jdx_op_t;

    typedef enum logic [2:0] {
        LEN_KEEP, LEN_INC, LEN_DEC, LEN_SUBRUN, LEN_CLEAR
    } len_op_t;

    typedef struct packed {
        logic    latch;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        idx_op_t idx_op;
        jdx_op_t jdx_op;
        len_op_t len_op;
        logic    hold_load;
        logic    val_load;
        logic    stat_load;
        logic    emit;
        logic    emit_last;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic proceed;
        logic idx_eq_pos;
        logic idx_lt_len;
        logic jdx_lt_len;
        logic sort_done;
        logic run_last;
        logic exch;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/core/positional_array_store.sv
// top level of the positional array store: controller plus datapath
// depends on pas_pkg, pas_ctrl, pas_datapath (with pas_ram) and assert_macros.svh
//
// channel  dir  tdata (low bit up)                               tuser      tlast
// s_       in   position, other_position, run_count, element,   operation  -
//               descending, zero pad
// m_       out  value, status, length                            -          last
//
// one item at a time; push, set, clear and refusals pass check and emit, get and pop add a capture
// insert and remove move each shifted entry with a ram read and then a ram write
// remove run reads, captures and emits each returned element, then shifts the entries above
// sort is an exchange sort over the n entries (one ram read per compare)
// a result waiting on m_tready stalls the next result, not the next transaction in
// reset clears the length and the handshake state only; the ram needs no clearing
`include "assert_macros.svh"

module positional_array_store #(
    parameter int DEPTH      = pas_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = pas_pkg::ELEM_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position, other_position, run_count, element, descending, zero pad
    input  logic [pas_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic [pas_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // value, status, length
    output logic [pas_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    pas_pkg::cmd_t  cmd;
    pas_pkg::stat_t stat;

    logic [pas_pkg::VALUE_W-1:0]  m_value;
    logic [pas_pkg::STATUS_W-1:0] m_status;
    logic [pas_pkg::LENGTH_W-1:0] m_length;

    pas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pas_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_in    (s_tuser),
        .pos_in   (s_tdata[5:0]),
        .pos2_in  (s_tdata[10:6]),
        .run_in   (s_tdata[16:11]),
        .elem_in  (s_tdata[48:17]),
        .desc_in  (s_tdata[49]),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_value  (m_value),
        .m_status (m_status),
        .m_length (m_length),
        .m_last   (m_tlast)
    );

    assign m_tdata = {m_length, m_status, m_value};

    `ASSERT_IMPLIES(a_refusal_zero_value, m_tvalid && (m_status != pas_pkg::ST_OK), m_value == '0, "refused transaction carries a nonzero value")
    `ASSERT_IMPLIES(a_nonlast_is_ok, m_tvalid && !m_tlast, m_status == pas_pkg::ST_OK, "non-final result with error status")
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accepting a transaction")

endmodule

// File: rtl/core/pas_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/pas_datapath.sv
// datapath: item fields, length, indexes, element ram, checks and result register
// depends on pas_pkg and pas_ram
module pas_datapath #(
    parameter int DEPTH      = pas_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = pas_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pas_pkg::OP_W-1:0]      op_in,
    input  logic [pas_pkg::POS_W-1:0]     pos_in,
    input  logic [pas_pkg::POS2_W-1:0]    pos2_in,
    input  logic [pas_pkg::RUN_W-1:0]     run_in,
    input  logic [pas_pkg::ELEM_IN_W-1:0] elem_in,
    input  logic                          desc_in,
    input  pas_pkg::cmd_t                 cmd,
    output pas_pkg::stat_t                stat,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [pas_pkg::VALUE_W-1:0]   m_value,
    output logic [pas_pkg::STATUS_W-1:0]  m_status,
    output logic [pas_pkg::LENGTH_W-1:0]  m_length,
    output logic                          m_last
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int CW     = ((LEN_W > pas_pkg::POS_W) ? LEN_W : pas_pkg::POS_W) + 2;

    pas_pkg::op_t     op_reg;
    logic [pas_pkg::POS_W-1:0]  pos_reg;
    logic [pas_pkg::POS2_W-1:0] pos2_reg;
    logic [pas_pkg::RUN_W-1:0]  run_reg;
    logic [ELEM_WIDTH-1:0]      elem_reg;
    logic                       desc_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [LEN_W-1:0]           idx_reg;
    logic [LEN_W-1:0]           jdx_reg;
    logic [ELEM_WIDTH-1:0]      hold_reg;
    logic [ELEM_WIDTH-1:0]      val_reg;
    pas_pkg::status_t           stat_reg;
    logic                       m_valid_reg;
    logic [pas_pkg::VALUE_W-1:0]  m_value_reg;
    logic [pas_pkg::STATUS_W-1:0] m_status_reg;
    logic [pas_pkg::LENGTH_W-1:0] m_length_reg;
    logic                         m_last_reg;

    logic [63:0]           elem_wide;
    logic [63:0]           val_wide;
    logic [CW-1:0]         p, p2, r, l, dep, k, ix, jx;
    logic [CW-1:0]         raddr_w, waddr_w;
    logic [ADDR_W-1:0]     raddr, waddr;
    logic [ELEM_WIDTH-1:0] wdata, rdata;
    pas_pkg::status_t      chk;
    logic                  noop;
    logic                  out_free;

    assign elem_wide = {32'b0, elem_in};
    assign val_wide  = 64'(val_reg);

    assign p   = CW'(pos_reg);
    assign p2  = CW'(pos2_reg);
    assign r   = CW'(run_reg);
    assign l   = CW'(len_reg);
    assign dep = CW'(DEPTH);
    assign ix  = CW'(idx_reg);
    assign jx  = CW'(jdx_reg);
    assign k   = (op_reg == pas_pkg::OP_RUN) ? r : CW'(1);

    // refusal checks in the order the operations test them
    always_comb begin
        chk  = pas_pkg::ST_OK;
        noop = 1'b0;
        unique case (op_reg)
            pas_pkg::OP_PUSH: begin
                if (l >= dep) chk = pas_pkg::ST_FULL;
            end
            pas_pkg::OP_INSERT: begin
                if (p > l) chk = pas_pkg::ST_RANGE;
                else if (l >= dep) chk = pas_pkg::ST_FULL;
            end
            pas_pkg::OP_POP: begin
                if (l == '0) chk = pas_pkg::ST_EMPTY;
            end
            pas_pkg::OP_REMOVE, pas_pkg::OP_GET, pas_pkg::OP_SET: begin
                if (l == '0) chk = pas_pkg::ST_EMPTY;
                else if (p >= l) chk = pas_pkg::ST_RANGE;
            end
            pas_pkg::OP_RUN: begin
                if (r == '0) begin
                    if (p > l) chk = pas_pkg::ST_RANGE;
                    else noop = 1'b1;
                end else if (l == '0) begin
                    chk = pas_pkg::ST_EMPTY;
                end else if (r > CW'(pas_pkg::MAX_RUN) || (p + r) > l) begin
                    chk = pas_pkg::ST_RANGE;
                end
            end
            pas_pkg::OP_SWAP: begin
                if (l == '0) chk = pas_pkg::ST_EMPTY;
                else if (p >= l || p2 >= l) chk = pas_pkg::ST_RANGE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (cmd.rd_sel)
            pas_pkg::RA_POS:    raddr_w = p;
            pas_pkg::RA_POS2:   raddr_w = p2;
            pas_pkg::RA_LENM1:  raddr_w = l - CW'(1);
            pas_pkg::RA_IDXM1:  raddr_w = ix - CW'(1);
            pas_pkg::RA_IDXK:   raddr_w = ix + k;
            pas_pkg::RA_POSJDX: raddr_w = p + jx;
            pas_pkg::RA_IDX:    raddr_w = ix;
            pas_pkg::RA_JDX:    raddr_w = jx;
            default:            raddr_w = ix;
        endcase
        unique case (cmd.wa_sel)
            pas_pkg::WA_LEN:  waddr_w = l;
            pas_pkg::WA_POS:  waddr_w = p;
            pas_pkg::WA_POS2: waddr_w = p2;
            pas_pkg::WA_IDX:  waddr_w = ix;
            pas_pkg::WA_JDX:  waddr_w = jx;
            default:          waddr_w = ix;
        endcase
        unique case (cmd.wd_sel)
            pas_pkg::WD_ELEM:  wdata = elem_reg;
            pas_pkg::WD_RDATA: wdata = rdata;
            pas_pkg::WD_HOLD:  wdata = hold_reg;
            default:           wdata = hold_reg;
        endcase
    end

    assign raddr = raddr_w[ADDR_W-1:0];
    assign waddr = waddr_w[ADDR_W-1:0];

    pas_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        stat.op         = op_reg;
        stat.proceed    = (chk == pas_pkg::ST_OK) && !noop;
        stat.idx_eq_pos = (ix == p);
        stat.idx_lt_len = (ix < l);
        stat.jdx_lt_len = (jx < l);
        stat.sort_done  = ((ix + CW'(1)) >= l);
        stat.run_last   = ((jx + CW'(1)) == r);
        stat.exch       = desc_reg ? (hold_reg < rdata) : (hold_reg > rdata);
        stat.out_free   = out_free;
    end

    // item fields and working values
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg   <= pas_pkg::op_t'(op_in);
            pos_reg  <= pos_in;
            pos2_reg <= pos2_in;
            run_reg  <= run_in;
            elem_reg <= elem_wide[ELEM_WIDTH-1:0];
            desc_reg <= desc_in;
            val_reg  <= '0;
        end else if (cmd.val_load) begin
            val_reg <= rdata;
        end
        if (cmd.hold_load) hold_reg <= rdata;
        if (cmd.stat_load) stat_reg <= chk;
        unique case (cmd.idx_op)
            pas_pkg::IDX_LEN:  idx_reg <= len_reg;
            pas_pkg::IDX_POS:  idx_reg <= p[LEN_W-1:0];
            pas_pkg::IDX_ZERO: idx_reg <= '0;
            pas_pkg::IDX_INC:  idx_reg <= idx_reg + LEN_W'(1);
            pas_pkg::IDX_DEC:  idx_reg <= idx_reg - LEN_W'(1);
            default: begin
            end
        endcase
        unique case (cmd.jdx_op)
            pas_pkg::JDX_ZERO:  jdx_reg <= '0;
            pas_pkg::JDX_IDXP1: jdx_reg <= idx_reg + LEN_W'(1);
            pas_pkg::JDX_INC:   jdx_reg <= jdx_reg + LEN_W'(1);
            default: begin
            end
        endcase
        if (cmd.emit) begin
            m_value_reg  <= val_wide[pas_pkg::VALUE_W-1:0];
            m_status_reg <= stat_reg;
            m_length_reg <= l[pas_pkg::LENGTH_W-1:0];
            m_last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (cmd.len_op)
                pas_pkg::LEN_INC:    len_reg <= len_reg + LEN_W'(1);
                pas_pkg::LEN_DEC:    len_reg <= len_reg - LEN_W'(1);
                pas_pkg::LEN_SUBRUN: len_reg <= len_reg - r[LEN_W-1:0];
                pas_pkg::LEN_CLEAR:  len_reg <= '0;
                default: begin
                end
            endcase
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;
    assign m_length = m_length_reg;
    assign m_last   = m_last_reg;

endmodule

// File: rtl/core/pas_ctrl.sv
// controller state machine: sequences ram reads, writes and result transactions
// depends on pas_pkg
module pas_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pas_pkg::stat_t stat,
    output pas_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        IDLE, CHECK, CAPTURE, INS_LOOP, INS_WR, REM_CAP, SH_LOOP, SH_WR,
        RUN_RD, RUN_CAP, RUN_EMIT, SW_A, SW_B, SW_C, SO_I, SO_LA, SO_J,
        SO_CMP, EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = CHECK;
                end
            end
            CHECK: begin
                cmd.stat_load = 1'b1;
                state_next    = EMIT;
                if (stat.proceed) begin
                    unique case (stat.op)
                        pas_pkg::OP_PUSH: begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = pas_pkg::WA_LEN;
                            cmd.wd_sel = pas_pkg::WD_ELEM;
                            cmd.len_op = pas_pkg::LEN_INC;
                        end
                        pas_pkg::OP_INSERT: begin
                            cmd.idx_op = pas_pkg::IDX_LEN;
                            state_next = INS_LOOP;
                        end
                        pas_pkg::OP_POP: begin
                            cmd.rd_sel = pas_pkg::RA_LENM1;
                            cmd.len_op = pas_pkg::LEN_DEC;
                            state_next = CAPTURE;
                        end
                        pas_pkg::OP_REMOVE: begin
                            cmd.rd_sel = pas_pkg::RA_POS;
                            cmd.len_op = pas_pkg::LEN_DEC;
                            cmd.idx_op = pas_pkg::IDX_POS;
                            state_next = REM_CAP;
                        end
                        pas_pkg::OP_RUN: begin
                            cmd.len_op = pas_pkg::LEN_SUBRUN;
                            cmd.jdx_op = pas_pkg::JDX_ZERO;
                            state_next = RUN_RD;
                        end
                        pas_pkg::OP_GET: begin
                            cmd.rd_sel = pas_pkg::RA_POS;
                            state_next = CAPTURE;
                        end
                        pas_pkg::OP_SET: begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = pas_pkg::WA_POS;
                            cmd.wd_sel = pas_pkg::WD_ELEM;
                        end
                        pas_pkg::OP_SWAP: begin
                            cmd.rd_sel = pas_pkg::RA_POS;
                            state_next = SW_A;
                        end
                        pas_pkg::OP_SORT: begin
                            cmd.idx_op = pas_pkg::IDX_ZERO;
                            state_next = SO_I;
                        end
                        pas_pkg::OP_CLEAR: begin
                            cmd.len_op = pas_pkg::LEN_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CAPTURE: begin
                cmd.val_load = 1'b1;
                state_next   = EMIT;
            end
            // open a gap at the insert position, top entry first
            INS_LOOP: begin
                if (stat.idx_eq_pos) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = pas_pkg::WA_POS;
                    cmd.wd_sel = pas_pkg::WD_ELEM;
                    cmd.len_op = pas_pkg::LEN_INC;
                    state_next = EMIT;
                end else begin
                    cmd.rd_sel = pas_pkg::RA_IDXM1;
                    state_next = INS_WR;
                end
            end
            INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = pas_pkg::WA_IDX;
                cmd.wd_sel = pas_pkg::WD_RDATA;
                cmd.idx_op = pas_pkg::IDX_DEC;
                state_next = INS_LOOP;
            end
            REM_CAP: begin
                cmd.val_load = 1'b1;
                state_next   = SH_LOOP;
            end
            // close the gap: length already holds the new count
            SH_LOOP: begin
                if (stat.idx_lt_len) begin
                    cmd.rd_sel = pas_pkg::RA_IDXK;
                    state_next = SH_WR;
                end else if (stat.op == pas_pkg::OP_REMOVE) begin
                    state_next = EMIT;
                end else begin
                    state_next = IDLE;
                end
            end
            SH_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = pas_pkg::WA_IDX;
                cmd.wd_sel = pas_pkg::WD_RDATA;
                cmd.idx_op = pas_pkg::IDX_INC;
                state_next = SH_LOOP;
            end
            RUN_RD: begin
                cmd.rd_sel = pas_pkg::RA_POSJDX;
                state_next = RUN_CAP;
            end
            RUN_CAP: begin
                cmd.val_load = 1'b1;
                state_next   = RUN_EMIT;
            end
            RUN_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = stat.run_last;
                    if (stat.run_last) begin
                        cmd.idx_op = pas_pkg::IDX_POS;
                        state_next = SH_LOOP;
                    end else begin
                        cmd.jdx_op = pas_pkg::JDX_INC;
                        state_next = RUN_RD;
                    end
                end
            end
            SW_A: begin
                cmd.hold_load = 1'b1;
                cmd.rd_sel    = pas_pkg::RA_POS2;
                state_next    = SW_B;
            end
            SW_B: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = pas_pkg::WA_POS;
                cmd.wd_sel = pas_pkg::WD_RDATA;
                state_next = SW_C;
            end
            SW_C: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = pas_pkg::WA_POS2;
                cmd.wd_sel = pas_pkg::WD_HOLD;
                state_next = EMIT;
            end
            // exchange sort: hold carries the running entry i
            SO_I: begin
                if (stat.sort_done) begin
                    state_next = EMIT;
                end else begin
                    cmd.rd_sel = pas_pkg::RA_IDX;
                    state_next = SO_LA;
                end
            end
            SO_LA: begin
                cmd.hold_load = 1'b1;
                cmd.jdx_op    = pas_pkg::JDX_IDXP1;
                state_next    = SO_J;
            end
            SO_J: begin
                if (stat.jdx_lt_len) begin
                    cmd.rd_sel = pas_pkg::RA_JDX;
                    state_next = SO_CMP;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = pas_pkg::WA_IDX;
                    cmd.wd_sel = pas_pkg::WD_HOLD;
                    cmd.idx_op = pas_pkg::IDX_INC;
                    state_next = SO_I;
                end
            end
            SO_CMP: begin
                if (stat.exch) begin
                    cmd.wr_en     = 1'b1;
                    cmd.wa_sel    = pas_pkg::WA_JDX;
                    cmd.wd_sel    = pas_pkg::WD_HOLD;
                    cmd.hold_load = 1'b1;
                end
                cmd.jdx_op = pas_pkg::JDX_INC;
                state_next = SO_J;
            end
            EMIT: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == IDLE);

endmodule

// File: test/positional_array_store_checker.sv
// checker for the positional array store: watches both channels, models the store
// and compares every result transaction field by field; depends on pas_pkg
module positional_array_store_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [pas_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [pas_pkg::OP_W-1:0]        s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [pas_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              pending
);

    typedef struct packed {
        logic [31:0]      value;
        pas_pkg::status_t status;
        logic [5:0]       length;
        logic             last;
    } result_t;

    logic [31:0] slot_copy [32];
    int unsigned fill;
    result_t     expected_results [$];

    function automatic void push_result(logic [31:0] v, pas_pkg::status_t st, logic lst);
        result_t r;
        r.value = v;
        r.status = st;
        r.length = fill[5:0];
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    // apply one operation to the store copy and queue its results
    function automatic void apply_op(logic [3:0] op, int unsigned pos, int unsigned pos2,
                                     int unsigned run, logic [31:0] elem, logic desc);
        logic [31:0]      value;
        logic [31:0]      taken [32];
        logic [31:0]      t;
        pas_pkg::status_t st;
        value = '0;
        st = pas_pkg::ST_OK;
        case (op)
            pas_pkg::OP_PUSH: begin
                if (fill >= 32) st = pas_pkg::ST_FULL;
                else begin
                    slot_copy[fill] = elem;
                    fill++;
                end
            end
            pas_pkg::OP_INSERT: begin
                if (pos > fill) st = pas_pkg::ST_RANGE;
                else if (fill >= 32) st = pas_pkg::ST_FULL;
                else begin
                    for (int i = fill; i > pos; i--) slot_copy[i] = slot_copy[i-1];
                    slot_copy[pos] = elem;
                    fill++;
                end
            end
            pas_pkg::OP_POP: begin
                if (fill == 0) st = pas_pkg::ST_EMPTY;
                else begin
                    fill--;
                    value = slot_copy[fill];
                end
            end
            pas_pkg::OP_REMOVE: begin
                if (fill == 0) st = pas_pkg::ST_EMPTY;
                else if (pos >= fill) st = pas_pkg::ST_RANGE;
                else begin
                    value = slot_copy[pos];
                    for (int i = pos; i + 1 < fill; i++) slot_copy[i] = slot_copy[i+1];
                    fill--;
                end
            end
            pas_pkg::OP_RUN: begin
                if (run == 0) st = (pos > fill) ? pas_pkg::ST_RANGE : pas_pkg::ST_OK;
                else if (fill == 0) st = pas_pkg::ST_EMPTY;
                else if (run > 32 || pos + run > fill) st = pas_pkg::ST_RANGE;
                else begin
                    for (int i = 0; i < run; i++) taken[i] = slot_copy[pos+i];
                    for (int i = pos; i + run < fill; i++) slot_copy[i] = slot_copy[i+run];
                    fill -= run;
                    for (int i = 0; i < run; i++)
                        push_result(taken[i], pas_pkg::ST_OK, i + 1 == run);
                    return;
                end
            end
            pas_pkg::OP_GET: begin
                if (fill == 0) st = pas_pkg::ST_EMPTY;
                else if (pos >= fill) st = pas_pkg::ST_RANGE;
                else value = slot_copy[pos];
            end
            pas_pkg::OP_SET: begin
                if (fill == 0) st = pas_pkg::ST_EMPTY;
                else if (pos >= fill) st = pas_pkg::ST_RANGE;
                else slot_copy[pos] = elem;
            end
            pas_pkg::OP_SWAP: begin
                if (fill == 0) st = pas_pkg::ST_EMPTY;
                else if (pos >= fill || pos2 >= fill) st = pas_pkg::ST_RANGE;
                else begin
                    t = slot_copy[pos];
                    slot_copy[pos] = slot_copy[pos2];
                    slot_copy[pos2] = t;
                end
            end
            pas_pkg::OP_SORT: begin
                for (int i = 0; i < fill; i++)
                    for (int j = i + 1; j < fill; j++)
                        if (desc ? (slot_copy[i] < slot_copy[j])
                                 : (slot_copy[i] > slot_copy[j])) begin
                            t = slot_copy[i];
                            slot_copy[i] = slot_copy[j];
                            slot_copy[j] = t;
                        end
            end
            pas_pkg::OP_CLEAR: fill = 0;
            default: ;
        endcase
        push_result(value, st, 1'b1);
    endfunction

    result_t got, exp_r;

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill = 0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                apply_op(s_tuser, s_tdata[5:0], s_tdata[10:6], s_tdata[16:11],
                         s_tdata[48:17], s_tdata[49]);
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[31:0];
                got.status = pas_pkg::status_t'(m_tdata[33:32]);
                got.length = m_tdata[39:34];
                got.last = m_tlast;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected value %h status %0d length %0d",
                                      " last %b, got value %h status %0d length %0d last %b"},
                                     exp_r.value, exp_r.status, exp_r.length, exp_r.last,
                                     got.value, got.status, got.length, got.last);
                    end
                end
            end
        end
        pending = expected_results.size();
    end
endmodule

// File: test/positional_array_store_test.sv
// testbench top for the positional array store: clock, reset, operation stimulus
// with bursty sender and stalling receiver; depends on pas_pkg and the checker
module positional_array_store_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          length_est = 0;
    bit          sending_done = 0;
    bit          hold_off = 0;
    bit          hold_req = 0;

    always #4 aclk = ~aclk;

    positional_array_store DUT (.*);

    positional_array_store_checker u_checker (.*);

    // one transaction, held valid until accepted, with the length estimate updated
    task automatic send_op(pas_pkg::op_t op, int pos, int pos2, int run, logic [31:0] elem,
                           logic desc);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'd0, desc, elem, run[5:0], pos2[4:0], pos[5:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        case (op)
            pas_pkg::OP_PUSH: if (length_est < 32) length_est++;
            pas_pkg::OP_INSERT: if (pos <= length_est && length_est < 32) length_est++;
            pas_pkg::OP_POP, pas_pkg::OP_REMOVE:
                if (length_est > 0 && (op == pas_pkg::OP_POP || pos < length_est))
                    length_est--;
            pas_pkg::OP_RUN: if (run > 0 && pos + run <= length_est) length_est -= run;
            pas_pkg::OP_CLEAR: length_est = 0;
            default: ;
        endcase
    endtask

    int burst_left = 0;
    task automatic gap();
        int g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            g = $urandom_range(0, 6);
            if (g > 0) begin
                s_tvalid <= 1'b0;
                repeat (g) @(negedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic random_op();
        int r;
        int p;
        int len;
        len = length_est;
        r = $urandom_range(0, 99);
        p = (len > 0) ? $urandom_range(0, len - 1) : 0;
        if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 63);
        if (r < 25) send_op(pas_pkg::OP_PUSH, 0, 0, 0, $urandom, $urandom);
        else if (r < 37) send_op(pas_pkg::OP_INSERT, (len > 0) ? $urandom_range(0, len) : 0,
                                 0, 0, $urandom, 0);
        else if (r < 44) send_op(pas_pkg::OP_POP, 0, 0, 0, 0, 0);
        else if (r < 52) send_op(pas_pkg::OP_REMOVE, p, 0, 0, 0, 0);
        else if (r < 58) send_op(pas_pkg::OP_RUN, p, 0,
                                 $urandom_range(0, (len > p) ? len - p : 3), 0, 0);
        else if (r < 70) send_op(pas_pkg::OP_GET, p, 0, 0, 0, 0);
        else if (r < 78) send_op(pas_pkg::OP_SET, p, 0, 0, $urandom, 0);
        else if (r < 87) send_op(pas_pkg::OP_SWAP, p,
                                 (len > 0) ? $urandom_range(0, len - 1) : 0, 0, 0, 0);
        else if (r < 92) send_op(pas_pkg::OP_SORT, $urandom, $urandom, $urandom, $urandom,
                                 $urandom);
        else if (r < 94) send_op(pas_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        else send_op(pas_pkg::op_t'($urandom_range(10, 15)), $urandom_range(0, 63),
                     $urandom_range(0, 31), $urandom_range(0, 63), $urandom, $urandom);
    endtask

    // receiver stall pattern, plus one long hold-off
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    // long receiver hold-off, timed in cycles
    initial begin
        wait (hold_req);
        hold_off = 1;
        repeat (400) @(posedge aclk);
        hold_off = 0;
    end

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // directed: empty cases, extremes, every operation but clear
        send_op(pas_pkg::OP_POP, 0, 0, 0, 0, 0);
        send_op(pas_pkg::OP_REMOVE, 0, 0, 0, 0, 0);
        send_op(pas_pkg::OP_GET, 0, 0, 0, 0, 0);
        send_op(pas_pkg::OP_SET, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_op(pas_pkg::OP_SWAP, 0, 0, 0, 0, 0);
        send_op(pas_pkg::OP_RUN, 0, 0, 0, 0, 0);
        send_op(pas_pkg::OP_RUN, 1, 0, 0, 0, 0);
        send_op(pas_pkg::OP_RUN, 0, 0, 5, 0, 0);
        send_op(pas_pkg::OP_INSERT, 1, 0, 0, 1, 0);
        send_op(pas_pkg::OP_INSERT, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_op(pas_pkg::OP_PUSH, 0, 0, 0, 32'h0, 0);
        send_op(pas_pkg::OP_INSERT, 2, 0, 0, 32'h8000_0001, 0);
        send_op(pas_pkg::OP_SWAP, 0, 31, 0, 0, 0);
        send_op(pas_pkg::OP_SWAP, 0, 2, 0, 0, 0);
        send_op(pas_pkg::OP_GET, 63, 0, 0, 0, 0);
        send_op(pas_pkg::OP_SORT, 0, 0, 0, 0, 1'b0);
        send_op(pas_pkg::OP_SORT, 0, 0, 0, 0, 1'b1);
        send_op(pas_pkg::OP_RUN, 1, 0, 63, 0, 0);
        send_op(pas_pkg::OP_RUN, 1, 0, 2, 0, 0);
        send_op(pas_pkg::op_t'(4'd15), 63, 31, 63, 32'hFFFF_FFFF, 1'b1);
        // fill to full, with the receiver held off for a long stretch
        hold_req = 1;
        for (int i = 0; i < 33; i++) begin
            send_op(pas_pkg::OP_PUSH, 0, 0, 0, $urandom, 0);
        end
        send_op(pas_pkg::OP_INSERT, 0, 0, 0, 5, 0);
        send_op(pas_pkg::OP_INSERT, 33, 0, 0, 5, 0);
        send_op(pas_pkg::OP_SORT, 0, 0, 0, 0, 1'b1);
        send_op(pas_pkg::OP_RUN, 0, 0, 32, 0, 0);
        // random part
        for (int i = 0; i < 50; i++) begin
            gap();
            random_op();
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
